// ===== hw/rtl/rational_add_multiply_unit_assert.svh =====
// Assertion macros for the rational add/multiply unit.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef RATIONAL_ADD_MULTIPLY_UNIT_ASSERT_SVH
`define RATIONAL_ADD_MULTIPLY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAMU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ramu_pkg.sv =====
// Shared types, codes and microcode for the rational add/multiply unit.
// No dependencies; used by ramu_divmul and rational_add_multiply_unit.
`timescale 1ns / 1ps

package ramu_pkg;

	// Intermediates are held as sign and magnitude of this width.
	localparam int MW    = 64;
	localparam int CNT_W = $clog2(MW);
	localparam int PC_W  = 3;

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} sval_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVF      = 2'd2;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_MUL = 1'b1;

	typedef enum logic [2:0] {
		R_AN = 3'd0,
		R_AD = 3'd1,
		R_BN = 3'd2,
		R_BD = 3'd3,
		R_T0 = 3'd4,
		R_T1 = 3'd5
	} reg_code_t;

	typedef enum logic [1:0] {
		UOP_RED = 2'd0,
		UOP_MUL = 2'd1,
		UOP_ADD = 2'd2,
		UOP_END = 2'd3
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t kind;
		reg_code_t src_a;
		reg_code_t src_b;
		reg_code_t dst;
	} uop_t;

	typedef struct packed {
		logic start;
		logic mul;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} unit_rsp_t;

	// Operation sequence for each command. The result always ends in AN / BN.
	function automatic uop_t ucode(input logic cmd, input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{UOP_END, R_AN, R_AN, R_AN};
		if (cmd == CMD_MUL) begin
			case (pc)
				3'd0: u = '{UOP_RED, R_AN, R_BD, R_AN};
				3'd1: u = '{UOP_RED, R_AD, R_BN, R_AN};
				3'd2: u = '{UOP_MUL, R_AN, R_BN, R_AN};
				3'd3: u = '{UOP_MUL, R_AD, R_BD, R_BN};
				default: u = '{UOP_END, R_AN, R_AN, R_AN};
			endcase
		end else begin
			case (pc)
				3'd0: u = '{UOP_RED, R_AN, R_AD, R_AN};
				3'd1: u = '{UOP_RED, R_BN, R_BD, R_AN};
				3'd2: u = '{UOP_MUL, R_AN, R_BD, R_T0};
				3'd3: u = '{UOP_MUL, R_AD, R_BN, R_T1};
				3'd4: u = '{UOP_ADD, R_T0, R_T1, R_AN};
				3'd5: u = '{UOP_MUL, R_AD, R_BD, R_BN};
				3'd6: u = '{UOP_RED, R_AN, R_BN, R_AN};
				default: u = '{UOP_END, R_AN, R_AN, R_AN};
			endcase
		end
		return u;
	endfunction

endpackage

// ===== hw/rtl/ramu_divmul.sv =====
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit per cycle.
// Depends on ramu_pkg.
`timescale 1ns / 1ps

module ramu_divmul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ramu_pkg::unit_req_t      req,
	input  logic [ramu_pkg::MW-1:0]  opa,
	input  logic [ramu_pkg::MW-1:0]  opb,
	output ramu_pkg::unit_rsp_t      rsp,
	output logic [ramu_pkg::MW-1:0]  quo,
	output logic [ramu_pkg::MW-1:0]  rem
);
	import ramu_pkg::*;

	logic             busy_q, mul_q, done_q, ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    acc_q, rem_q, b_q, mb_q;
	logic [MW:0]      op1, op2;
	logic [MW+1:0]    sum;

	// One adder serves both: subtract the divisor, or add the multiplicand.
	always_comb begin
		if (mul_q) begin
			op1 = {acc_q, 1'b0};
			op2 = {1'b0, (mb_q[MW-1] ? b_q : '0)};
		end else begin
			op1 = {rem_q, acc_q[MW-1]};
			op2 = ~{1'b0, b_q};
		end
		sum = {1'b0, op1} + {1'b0, op2} + (MW+2)'(!mul_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mul_q  <= req.mul;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			b_q   <= opb;
			mb_q  <= opa;
			rem_q <= '0;
			acc_q <= req.mul ? '0 : opa;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= sum[MW-1:0];
				mb_q  <= {mb_q[MW-2:0], 1'b0};
				ovf_q <= ovf_q | sum[MW+1] | sum[MW];
			end else begin
				rem_q <= sum[MW+1] ? sum[MW-1:0] : op1[MW-1:0];
				acc_q <= {acc_q[MW-2:0], sum[MW+1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign quo      = acc_q;
	assign rem      = rem_q;

endmodule

// ===== hw/rtl/rational_add_multiply_unit.sv =====
// Top level of the rational add/multiply unit: sequencer, operand registers, output stage.
// Depends on ramu_pkg, ramu_divmul and rational_add_multiply_unit_assert.svh.
`timescale 1ns / 1ps

// Takes one pair of signed fractions and a command per transfer and returns one
// fraction with a status code. All divides and multiplies run on one shared bit-serial
// unit. Each reduction is one divide per Euclid step plus two exact divides.
// A zero operand or a zero denominator skips the arithmetic: S_CHECK hands its result
// straight to S_OUT. The next item is taken once the previous result has been placed
// in the output register.
module rational_add_multiply_unit #(
	parameter int INT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic signed [INT_WIDTH-1:0] a_num,
	input  logic signed [INT_WIDTH-1:0] a_den,
	input  logic signed [INT_WIDTH-1:0] b_num,
	input  logic signed [INT_WIDTH-1:0] b_den,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [INT_WIDTH-1:0] res_num,
	output logic signed [INT_WIDTH-1:0] res_den,
	output logic [1:0]                  status
);
	import ramu_pkg::*;

	localparam int W = INT_WIDTH;
	localparam logic [MW-1:0] MAXPOS = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_FETCH = 8'b0000_0100,
		S_GCD   = 8'b0000_1000,
		S_QX    = 8'b0001_0000,
		S_QY    = 8'b0010_0000,
		S_MUL   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	function automatic sval_t dec(input logic [W-1:0] v);
		sval_t         s;
		logic [W-1:0] t;
		s.neg = v[W-1];
		t     = s.neg ? (~v + 1'b1) : v;
		s.mag = MW'(t);
		return s;
	endfunction

	function automatic logic [W-1:0] enc(input sval_t s);
		logic [MW-1:0] t;
		t = s.neg ? (~s.mag + 1'b1) : s.mag;
		return t[W-1:0];
	endfunction

	function automatic logic fits(input sval_t s);
		return s.neg ? (s.mag <= MAXPOS + 1'b1) : (s.mag <= MAXPOS);
	endfunction

	function automatic sval_t pick(input reg_code_t c, input sval_t an, input sval_t ad,
			input sval_t bn, input sval_t bd, input sval_t t0, input sval_t t1);
		sval_t r;
		case (c)
			R_AN: r = an;
			R_AD: r = ad;
			R_BN: r = bn;
			R_BD: r = bd;
			R_T0: r = t0;
			R_T1: r = t1;
			default: r = an;
		endcase
		return r;
	endfunction

	state_t          state_q;
	logic            cmd_q, wait_q, pos_q;
	logic [PC_W-1:0] pc_q;
	sval_t           an_q, ad_q, bn_q, bd_q, t0_q, t1_q, g_q;
	logic [MW-1:0]   p_q, q_q;
	logic [W-1:0]    pnum_q, pden_q;
	logic [1:0]      pst_q;
	logic            out_valid_q;
	logic [W-1:0]    res_num_q, res_den_q;
	logic [1:0]      status_q;

	uop_t            uop;
	sval_t           x, y;
	unit_req_t       unit_req;
	unit_rsp_t       unit_rsp;
	logic [MW-1:0]   unit_a, unit_b, unit_quo, unit_rem;

	sval_t           add_res;
	logic            add_ovf, add_same, add_xge;
	logic [MW:0]     add_sum;

	logic            wr_en;
	reg_code_t       wr_code;
	sval_t           wr_val;

	assign uop = ucode(cmd_q, pc_q);
	assign x   = pick(uop.src_a, an_q, ad_q, bn_q, bd_q, t0_q, t1_q);
	assign y   = pick(uop.src_b, an_q, ad_q, bn_q, bd_q, t0_q, t1_q);

	// Signed add of two sign-magnitude values.
	always_comb begin
		add_same = (x.neg == y.neg);
		add_xge  = (x.mag >= y.mag);
		add_sum  = {1'b0, x.mag} + {1'b0, y.mag};
		add_ovf  = add_same && add_sum[MW];
		if (add_same) begin
			add_res.mag = add_sum[MW-1:0];
		end else if (add_xge) begin
			add_res.mag = x.mag - y.mag;
		end else begin
			add_res.mag = y.mag - x.mag;
		end
		if (add_same || add_xge) begin
			add_res.neg = x.neg && (add_res.mag != '0);
		end else begin
			add_res.neg = y.neg;
		end
	end

	always_comb begin
		unit_req.start = 1'b0;
		unit_req.mul   = 1'b0;
		unit_a         = x.mag;
		unit_b         = y.mag;
		case (state_q)
			S_GCD: begin
				unit_req.start = !wait_q;
				unit_a         = p_q;
				unit_b         = q_q;
			end
			S_QX: begin
				unit_req.start = !wait_q;
				unit_b         = g_q.mag;
			end
			S_QY: begin
				unit_req.start = !wait_q;
				unit_a         = y.mag;
				unit_b         = g_q.mag;
			end
			S_MUL: begin
				unit_req.start = !wait_q;
				unit_req.mul   = 1'b1;
			end
			default: ;
		endcase
	end

	ramu_divmul u_divmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.opa    (unit_a),
		.opb    (unit_b),
		.rsp    (unit_rsp),
		.quo    (unit_quo),
		.rem    (unit_rem)
	);

	// Operand register write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_code = uop.dst;
		wr_val  = add_res;
		case (state_q)
			S_FETCH: wr_en = (uop.kind == UOP_ADD) && !add_ovf && (add_res.mag != '0);
			S_QX: begin
				wr_en       = wait_q && unit_rsp.done;
				wr_code     = uop.src_a;
				wr_val.mag  = unit_quo;
				wr_val.neg  = (unit_quo != '0) && (x.neg != g_q.neg);
			end
			S_QY: begin
				wr_en       = wait_q && unit_rsp.done;
				wr_code     = uop.src_b;
				wr_val.mag  = unit_quo;
				wr_val.neg  = (unit_quo != '0) && (y.neg != g_q.neg);
			end
			S_MUL: begin
				wr_en       = wait_q && unit_rsp.done && !unit_rsp.ovf;
				wr_val.mag  = unit_quo;
				wr_val.neg  = (unit_quo != '0) && (x.neg != y.neg);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			an_q <= dec(a_num);
			ad_q <= dec(a_den);
			bn_q <= dec(b_num);
			bd_q <= dec(b_den);
		end else if (wr_en) begin
			case (wr_code)
				R_AN: an_q <= wr_val;
				R_AD: ad_q <= wr_val;
				R_BN: bn_q <= wr_val;
				R_BD: bd_q <= wr_val;
				R_T0: t0_q <= wr_val;
				R_T1: t1_q <= wr_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			pc_q        <= '0;
			cmd_q       <= CMD_ADD;
			out_valid_q <= 1'b0;
			pos_q       <= 1'b0;
			g_q         <= '0;
			p_q         <= '0;
			q_q         <= '0;
			pnum_q      <= '0;
			pden_q      <= '0;
			pst_q       <= ST_OK;
			res_num_q   <= '0;
			res_den_q   <= '0;
			status_q    <= ST_OK;
		end else begin
			if (unit_req.start) begin
				wait_q <= 1'b1;
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						pc_q    <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pnum_q  <= '0;
					pden_q  <= W'(1);
					pst_q   <= ST_OK;
					state_q <= S_OUT;
					if (ad_q.mag == '0 || bd_q.mag == '0) begin
						pst_q <= ST_ZERO_DEN;
					end else if (cmd_q == CMD_MUL) begin
						if (an_q.mag != '0 && bn_q.mag != '0) begin
							state_q <= S_FETCH;
						end
					end else if (an_q.mag == '0 && bn_q.mag == '0) begin
						pst_q <= ST_OK;
					end else if (an_q.mag == '0) begin
						pnum_q <= enc(bn_q);
						pden_q <= enc(bd_q);
					end else if (bn_q.mag == '0) begin
						pnum_q <= enc(an_q);
						pden_q <= enc(ad_q);
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					case (uop.kind)
						UOP_RED: begin
							p_q     <= x.mag;
							q_q     <= y.mag;
							pos_q   <= 1'b1;
							state_q <= S_GCD;
						end
						UOP_MUL: state_q <= S_MUL;
						UOP_ADD: begin
							if (add_ovf || add_res.mag == '0) begin
								pnum_q  <= '0;
								pden_q  <= W'(1);
								pst_q   <= add_ovf ? ST_OVF : ST_OK;
								state_q <= S_OUT;
							end else begin
								pc_q <= pc_q + 1'b1;
							end
						end
						default: begin
							state_q <= S_OUT;
							if (fits(an_q) && fits(bn_q)) begin
								pnum_q <= enc(an_q);
								pden_q <= enc(bn_q);
								pst_q  <= ST_OK;
							end else begin
								pnum_q <= '0;
								pden_q <= W'(1);
								pst_q  <= ST_OVF;
							end
						end
					endcase
				end
				S_GCD: begin
					if (wait_q && unit_rsp.done) begin
						wait_q <= 1'b0;
						if (unit_rem == '0) begin
							// The sign of the divisor follows the parity of the step count.
							g_q.mag <= q_q;
							g_q.neg <= pos_q ? y.neg : x.neg;
							state_q <= S_QX;
						end else begin
							p_q   <= q_q;
							q_q   <= unit_rem;
							pos_q <= !pos_q;
						end
					end
				end
				S_QX: begin
					if (wait_q && unit_rsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_QY;
					end
				end
				S_QY: begin
					if (wait_q && unit_rsp.done) begin
						wait_q  <= 1'b0;
						pc_q    <= pc_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_MUL: begin
					if (wait_q && unit_rsp.done) begin
						wait_q <= 1'b0;
						if (unit_rsp.ovf) begin
							pnum_q  <= '0;
							pden_q  <= W'(1);
							pst_q   <= ST_OVF;
							state_q <= S_OUT;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= S_FETCH;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						res_num_q   <= pnum_q;
						res_den_q   <= pden_q;
						status_q    <= pst_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = status_q;

`include "rational_add_multiply_unit_assert.svh"

	`RAMU_ASSERT_NEXT(a_no_accept_while_busy, in_valid && in_ready, !in_ready,
		"Input accepted again in the cycle after a transfer.")
	`RAMU_ASSERT_NOW(a_flag_gives_zero, out_valid && status != ST_OK,
		res_num == '0 && res_den == 1, "Flagged result is not 0/1.")
	`RAMU_ASSERT_NOW(a_done_when_waiting, unit_rsp.done,
		wait_q && (state_q == S_GCD || state_q == S_QX || state_q == S_QY || state_q == S_MUL),
		"Arithmetic unit finished while the sequencer was not waiting for it.")
	`RAMU_ASSERT_NOW(a_start_when_idle, unit_req.start, !wait_q,
		"Arithmetic unit started twice for one operation.")

endmodule
